@@ rtl/core/pulse_burst_energy_averager_macros.svh @@
// Assertion macros shared by the checker files of the burst energy averager.
// Needs nothing else; include by bare file name.
`ifndef PULSE_BURST_ENERGY_AVERAGER_MACROS_SVH
`define PULSE_BURST_ENERGY_AVERAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PBEA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbea check failed");

// Next-cycle implication, disabled while reset is low
`define PBEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbea check failed");

`endif

@@ rtl/core/pbea_pkg.sv @@
// Shared constants, types and structs of the burst energy averager.
// No dependencies; every module of the block imports it.
package pbea_pkg;

    // Sizing
    localparam int RING_DEPTH  = 25;
    localparam int SAMPLE_BITS = 10;
    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = 10;
    localparam int CHAN_W      = 2;
    localparam int SUM_W       = 16;
    localparam int VAL_W       = 13;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int RING_AW     = IDX_W + 1;
    localparam int RING_WORDS  = 2 ** RING_AW;
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int ACC_W       = VAL_W + IDX_W;

    // Stream word layout
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;
    localparam int OUT_BITS    = 2 * VAL_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Burst sum divided by ten: multiply by a rounded-up reciprocal
    localparam int BURST_DIVISOR = 10;
    localparam int DIV_SHIFT     = SUM_W + $clog2(BURST_DIVISOR);
    localparam int DIV_RECIP_W   = DIV_SHIFT - $clog2(BURST_DIVISOR) + 1;
    localparam int DIV_PROD_W    = SUM_W + DIV_RECIP_W;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
        DIV_RECIP_W'((2 ** DIV_SHIFT + BURST_DIVISOR - 1) / BURST_DIVISOR);

    // Ring sum divided by the ring depth, same scheme
    localparam int MEAN_SHIFT   = ACC_W + IDX_W;
    localparam int MEAN_RECIP_W = ACC_W + 1;
    localparam int MEAN_PROD_W  = ACC_W + MEAN_RECIP_W;
    localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
        MEAN_RECIP_W'((2 ** MEAN_SHIFT + RING_DEPTH - 1) / RING_DEPTH);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ZERO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LEVEL = 2'd2;
    localparam logic [LEVEL_W-1:0]   LEVEL_ONE_RST  = 10'd10;
    localparam logic [LEVEL_W-1:0]   LEVEL_ZERO_RST = 10'd30;
    localparam logic [LEVEL_W-1:0]   EDGE_LEVEL_RST = 10'd100;

    // Highest channel tag that is processed
    localparam logic [CHAN_W-1:0] CHAN_ONE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MEAN,
        ST_RES
    } t_state;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        logic [VAL_W-1:0]   data;
    } t_ring_wr;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
    } t_ring_rd;

    typedef struct packed {
        logic start;
        logic chan;
    } t_mean_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } t_mean_rsp;

endpackage

@@ rtl/core/pbea_ring.sv @@
// Burst ring storage for both channels: one write port, one registered read port.
// Depends on pbea_pkg for widths and the port structs.
module pbea_ring (
    input  logic                      i_clk,
    input  pbea_pkg::t_ring_wr        i_wr,
    input  pbea_pkg::t_ring_rd        i_rd,
    output logic [pbea_pkg::VAL_W-1:0] o_rd_data
);
    import pbea_pkg::*;

    logic [VAL_W-1:0] r_mem [RING_WORDS];
    logic [VAL_W-1:0] r_rd_data;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read entry, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/pbea_mean.sv @@
// Ring mean unit: sweeps one channel's ring, sums it and divides by the depth.
// Depends on pbea_pkg; reads the ring through pbea_ring's read port.
module pbea_mean (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pbea_pkg::t_mean_req        i_req,
    output pbea_pkg::t_ring_rd         o_rd,
    input  logic [pbea_pkg::VAL_W-1:0] i_rd_data,
    output pbea_pkg::t_mean_rsp        o_rsp
);
    import pbea_pkg::*;

    logic                   r_busy;
    logic                   r_rd_vld;
    logic                   r_prod_vld;
    logic                   r_chan;
    logic [CNT_W-1:0]       r_cnt;
    logic [ACC_W-1:0]       r_acc;
    logic [MEAN_PROD_W-1:0] r_prod;
    logic                   rd_en;

    // Issue one read per cycle until every entry is requested
    assign rd_en     = r_busy && (r_cnt != CNT_W'(RING_DEPTH));
    assign o_rd.en   = rd_en;
    assign o_rd.addr = {r_chan, r_cnt[IDX_W-1:0]};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= rd_en;
            r_prod_vld <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && !rd_en && !r_rd_vld) begin
                r_busy     <= 1'b0;
                r_prod_vld <= 1'b1;
            end
        end
    end

    // Address counter, accumulator and reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_chan <= i_req.chan;
            r_cnt  <= '0;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_rd_vld) begin
                r_acc <= r_acc + ACC_W'(i_rd_data);
            end
            if (!rd_en && !r_rd_vld) begin
                r_prod <= MEAN_PROD_W'(r_acc) * MEAN_PROD_W'(MEAN_RECIP);
            end
        end
    end

    assign o_rsp.done  = r_prod_vld;
    assign o_rsp.value = r_prod[MEAN_SHIFT +: VAL_W];

endmodule

@@ rtl/core/pulse_burst_energy_averager.sv @@
// Top level of the burst energy averager: control sequencer, per-channel state,
// configuration registers and output register. Uses pbea_pkg, pbea_ring, pbea_mean.
//
//  channel   | direction | tdata / data             | tuser / index
//  ----------+-----------+--------------------------+----------------------
//  s_axis    | in        | sample                   | chan
//  m_axis    | out       | burst_value, mean_value, | burst_done, mean_done
//            |           | edge_count               |
//  cfg       | in        | register value (10 bit)  | register index
//
// A plain sample passes ST_EVAL and ST_RES before the next accept, and its word is loaded
// into the output register in ST_RES; a sample that ends a burst also passes ST_DIV (/10).
// A ring wrap then passes ST_MEAN, which sweeps the channel's ring through the single read
// port, one entry a cycle.
// Reset is synchronous; ring contents stay undefined and need no clearing pass.
// One item is in work at a time; while the output word stalls, the next result waits.
module pulse_burst_energy_averager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pbea_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] sample
    input  logic [pbea_pkg::CHAN_W-1:0]      s_axis_tuser,  // [1:0] chan
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [12:0] burst_value, [25:13] mean_value, [33:26] edge_count
    output logic [pbea_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [pbea_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // [0] burst_done, [1] mean_done
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pbea_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pbea_pkg::LEVEL_W-1:0]     i_cfg_data
);
    import pbea_pkg::*;

    t_state r_state, n_state;

    // Configuration
    logic [LEVEL_W-1:0] r_lvl_one, r_lvl_zero, r_edge;

    // Per-channel state and the edge counter shared by both channels
    logic               r_above  [2];
    logic               r_active [2];
    logic [SUM_W-1:0]   r_sum    [2];
    logic [IDX_W-1:0]   r_idx    [2];
    logic [VAL_W-1:0]   r_mean   [2];
    logic [COUNT_W-1:0] r_count;

    // Item in work
    logic [SAMPLE_W-1:0]   r_sample;
    logic [CHAN_W-1:0]     r_chan;
    logic [DIV_PROD_W-1:0] r_prod10;
    logic                  r_res_bdone, r_res_mdone;
    logic [VAL_W-1:0]      r_res_bval, r_res_mval;

    // Output register
    logic               r_m_valid;
    logic               r_m_bdone, r_m_mdone;
    logic [VAL_W-1:0]   r_m_bval, r_m_mval;
    logic [COUNT_W-1:0] r_m_count;

    logic               accept, out_load;
    logic               c, chan_ok, above_lvl, rise, fall, idx_last;
    logic [LEVEL_W-1:0] level;
    logic [VAL_W-1:0]   bval10;
    t_ring_wr           ring_wr;
    t_ring_rd           ring_rd;
    t_mean_req          mean_req;
    t_mean_rsp          mean_rsp;
    logic [VAL_W-1:0]   ring_rd_data;

    // Decode the item in work
    assign c         = r_chan[0];
    assign chan_ok   = (r_chan <= CHAN_ONE);
    assign level     = c ? r_lvl_one : r_lvl_zero;
    assign above_lvl = (r_sample > level);
    assign rise      = (r_sample > r_edge) && !r_above[c];
    assign fall      = (r_sample < r_edge) && r_above[c];
    assign idx_last  = (r_idx[c] == IDX_W'(RING_DEPTH - 1));
    assign bval10    = r_prod10[DIV_SHIFT +: VAL_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Ring write and mean start, both from the divide step
    assign ring_wr.en     = (r_state == ST_DIV);
    assign ring_wr.addr   = {c, r_idx[c]};
    assign ring_wr.data   = bval10;
    assign mean_req.start = (r_state == ST_DIV) && idx_last;
    assign mean_req.chan  = c;

    pbea_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd      (ring_rd),
        .o_rd_data (ring_rd_data)
    );

    pbea_mean u_mean (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mean_req),
        .o_rd      (ring_rd),
        .i_rd_data (ring_rd_data),
        .o_rsp     (mean_rsp)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and output load
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (chan_ok && !above_lvl && r_active[c]) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_RES;
                end
            end
            ST_DIV: begin
                n_state = idx_last ? ST_MEAN : ST_RES;
            end
            ST_MEAN: begin
                if (mean_rsp.done) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (!r_m_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration, channel state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_one  <= LEVEL_ONE_RST;
            r_lvl_zero <= LEVEL_ZERO_RST;
            r_edge     <= EDGE_LEVEL_RST;
            r_above    <= '{default: 1'b0};
            r_active   <= '{default: 1'b0};
            r_sum      <= '{default: '0};
            r_idx      <= '{default: '0};
            r_mean     <= '{default: '0};
            r_count    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            // Register write
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LEVEL_ONE:  r_lvl_one  <= i_cfg_data;
                    CFG_LEVEL_ZERO: r_lvl_zero <= i_cfg_data;
                    CFG_EDGE_LEVEL: r_edge     <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                ST_EVAL: begin
                    if (chan_ok) begin
                        // Edge detector; channel one counts, channel zero clears
                        if (rise) begin
                            r_above[c] <= 1'b1;
                            r_count    <= c ? (r_count + COUNT_W'(1)) : '0;
                        end
                        if (fall) begin
                            r_above[c] <= 1'b0;
                        end
                        // Burst accumulator
                        if (above_lvl) begin
                            r_sum[c]    <= r_sum[c] + SUM_W'(r_sample);
                            r_active[c] <= 1'b1;
                        end else if (r_active[c]) begin
                            r_sum[c]    <= '0;
                            r_active[c] <= 1'b0;
                        end
                    end
                end
                ST_DIV: begin
                    r_idx[c] <= idx_last ? '0 : (r_idx[c] + IDX_W'(1));
                end
                ST_MEAN: begin
                    if (mean_rsp.done) begin
                        r_mean[c] <= mean_rsp.value;
                    end
                end
                default: ;
            endcase

            // Hold the word until taken
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Item payload and result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= s_axis_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;
            r_chan   <= s_axis_tuser;
        end

        case (r_state)
            ST_EVAL: begin
                r_res_bdone <= 1'b0;
                r_res_bval  <= '0;
                r_res_mdone <= 1'b0;
                r_res_mval  <= chan_ok ? r_mean[c] : '0;
                r_prod10    <= DIV_PROD_W'(r_sum[c]) * DIV_PROD_W'(DIV_RECIP);
            end
            ST_DIV: begin
                r_res_bdone <= 1'b1;
                r_res_bval  <= bval10;
            end
            ST_MEAN: begin
                if (mean_rsp.done) begin
                    r_res_mdone <= 1'b1;
                    r_res_mval  <= mean_rsp.value;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_m_bdone <= r_res_bdone;
            r_m_bval  <= r_res_bval;
            r_m_mdone <= r_res_mdone;
            r_m_mval  <= r_res_mval;
            r_m_count <= r_count;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), r_m_count, r_m_mval, r_m_bval};
    assign m_axis_tuser  = {r_m_mdone, r_m_bdone};

endmodule

@@ rtl/core/pbea_checker.sv @@
// Port-level checks of the burst energy averager, bound to the top level.
// Depends on pbea_pkg and pulse_burst_energy_averager_macros.svh.
`include "pulse_burst_energy_averager_macros.svh"

module pbea_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pbea_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [pbea_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import pbea_pkg::*;

    logic                                    out_stall;
    logic [OUT_USER_W+OUT_TDATA_W-1:0]       out_word;
    logic [VAL_W-1:0]                        out_bval;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};
    assign out_bval  = m_axis_tdata[VAL_W-1:0];

    // Stalled output word holds
    `PBEA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // One item in work: no accept right after an accept
    `PBEA_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A new mean only comes with the burst that wrapped the ring
    `PBEA_ASSERT_SAME(a_mean_burst, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])

    // No burst ended: burst value reads zero
    `PBEA_ASSERT_SAME(a_bval_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], out_bval == '0)

endmodule

bind pulse_burst_energy_averager pbea_checker u_pbea_checker (.*);

@@ tb/pulse_burst_energy_averager_tb.sv @@
// Self-checking bench for pulse_burst_energy_averager: directed rows, random bursts, counter wrap.
// A behavioral predictor checks each word but those of typed rows. Depends on pbea_pkg and the RTL only.
`timescale 1ns / 100ps

module pulse_burst_energy_averager_tb;
    import pbea_pkg::*;

    // Channel tags carried in s_axis_tuser
    localparam logic [CHAN_W-1:0] TAG_ZERO    = 2'd0;
    localparam logic [CHAN_W-1:0] TAG_ONE     = CHAN_ONE;
    localparam logic [CHAN_W-1:0] TAG_IGNORED = 2'd2;
    localparam logic [CHAN_W-1:0] TAG_UNUSED  = 2'd3;

    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int DIRECTED_COUNT = 20;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int SHOWN_LIMIT    = 10;

    typedef struct packed {
        logic               burst_done;
        logic [VAL_W-1:0]   burst_value;
        logic               mean_done;
        logic [VAL_W-1:0]   mean_value;
        logic [COUNT_W-1:0] edge_count;
    } burst_report_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   chan;
        logic                typed;
        burst_report_t       want;
    } stim_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [9:0] sample
    logic [CHAN_W-1:0]      s_axis_tuser;   // [1:0] chan
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [12:0] burst_value, [25:13] mean_value,
                                            // [33:26] edge_count
    logic [OUT_USER_W-1:0]  m_axis_tuser;   // [0] burst_done, [1] mean_done
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [LEVEL_W-1:0]     i_cfg_data;

    // Predictor state: thresholds and per-channel burst bookkeeping
    logic [LEVEL_W-1:0] lvl_one;
    logic [LEVEL_W-1:0] lvl_zero;
    logic [LEVEL_W-1:0] edge_lvl;
    logic               burst_on [2];
    logic               above_edge [2];
    logic [SUM_W-1:0]   burst_sums [2];
    logic [VAL_W-1:0]   ring_vals [2][RING_DEPTH];
    int unsigned        ring_pos [2];
    logic [VAL_W-1:0]   channel_means [2];
    logic [COUNT_W-1:0] crossings;

    burst_report_t pending_reports [$];
    int            failures = 0;
    int            send_gap_pct = 0;
    int            recv_stall_pct = 0;

    // Default thresholds: level one 10, level zero 30, edge 100
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{10'd0,    TAG_ZERO,    1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd0}},
        '{10'd1023, TAG_ONE,     1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd1}},
        '{10'd0,    TAG_ONE,     1'b1, '{1'b1, 13'd102, 1'b0, 13'd0, 8'd1}},
        '{10'd1023, TAG_IGNORED, 1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd1}},
        '{10'd1023, TAG_UNUSED,  1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd1}},
        '{10'd100,  TAG_ONE,     1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd1}},
        '{10'd101,  TAG_ONE,     1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd2}},
        '{10'd100,  TAG_ONE,     1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd2}},
        '{10'd10,   TAG_ONE,     1'b1, '{1'b1, 13'd30,  1'b0, 13'd0, 8'd2}},
        '{10'd31,   TAG_ZERO,    1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd2}},
        '{10'd101,  TAG_ZERO,    1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd0}},
        '{10'd30,   TAG_ZERO,    1'b1, '{1'b1, 13'd13,  1'b0, 13'd0, 8'd0}},
        '{10'd1023, TAG_ZERO,    1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd0}},
        '{10'd99,   TAG_ZERO,    1'b1, '{1'b0, 13'd0,   1'b0, 13'd0, 8'd0}},
        '{10'd0,    TAG_ZERO,    1'b1, '{1'b1, 13'd112, 1'b0, 13'd0, 8'd0}},
        '{10'd682,  TAG_ONE,     1'b0, '0},
        '{10'd341,  TAG_ONE,     1'b0, '0},
        '{10'd5,    TAG_ONE,     1'b0, '0},
        '{10'd512,  TAG_ZERO,    1'b0, '0},
        '{10'd0,    TAG_ZERO,    1'b0, '0}
    };

    pulse_burst_energy_averager u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Advance the predictor by one accepted sample and return the expected word
    function automatic burst_report_t compute_burst_report(input logic [SAMPLE_W-1:0] s,
                                                           input logic [CHAN_W-1:0] ch);
        burst_report_t r;
        int            c;
        logic [LEVEL_W-1:0] lvl;
        int unsigned   acc;
        r = '0;
        if (ch <= TAG_ONE) begin
            c   = int'(ch);
            lvl = (ch == TAG_ONE) ? lvl_one : lvl_zero;
            // Rising crossing counts on channel one, clears on channel zero
            if (s > edge_lvl && !above_edge[c]) begin
                above_edge[c] = 1'b1;
                if (ch == TAG_ONE) crossings = crossings + COUNT_W'(1);
                else crossings = '0;
            end
            if (s < edge_lvl && above_edge[c]) above_edge[c] = 1'b0;
            // Accumulate while above level, store sum/10 on the closing sample
            if (s > lvl) begin
                burst_sums[c] = burst_sums[c] + SUM_W'(s);
                burst_on[c]   = 1'b1;
            end else if (burst_on[c]) begin
                burst_on[c]                 = 1'b0;
                r.burst_done                = 1'b1;
                r.burst_value               = VAL_W'(burst_sums[c] / BURST_DIVISOR);
                ring_vals[c][ring_pos[c]]   = r.burst_value;
                burst_sums[c]               = '0;
                ring_pos[c]                 = ring_pos[c] + 1;
                if (ring_pos[c] == RING_DEPTH) begin
                    ring_pos[c] = 0;
                    acc = 0;
                    for (int i = 0; i < RING_DEPTH; i++) acc += ring_vals[c][i];
                    channel_means[c] = VAL_W'(acc / RING_DEPTH);
                    r.mean_done      = 1'b1;
                end
            end
            r.mean_value = channel_means[c];
        end
        r.edge_count = crossings;
        return r;
    endfunction

    // Present one sample word, with an optional gap, and hold until accepted
    task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] ch);
        int gap;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, s};
        s_axis_tuser  <= ch;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
    endtask

    task automatic push_sample(input int s, input logic [CHAN_W-1:0] ch);
        send_word(SAMPLE_W'(s), ch);
        pending_reports.push_back(compute_burst_report(SAMPLE_W'(s), ch));
    endtask

    task automatic drop_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Write one threshold register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= LEVEL_W'(val);
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        case (idx)
            CFG_LEVEL_ONE:  lvl_one  = LEVEL_W'(val);
            CFG_LEVEL_ZERO: lvl_zero = LEVEL_W'(val);
            CFG_EDGE_LEVEL: edge_lvl = LEVEL_W'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_thresholds(input int one, input int zero, input int edge_at);
        wait_drained();
        write_reg(CFG_LEVEL_ONE, one);
        write_reg(CFG_LEVEL_ZERO, zero);
        write_reg(CFG_EDGE_LEVEL, edge_at);
    endtask

    // Well-formed bursts with random content, sprinkled with noise words.
    // A long burst of high samples can wrap the 16-bit sum.
    task automatic run_bursts(input int n_items, input bit allow_long);
        int sent;
        int lvl;
        int len;
        int lo;
        bit long_run;
        bit need_long;
        logic [CHAN_W-1:0] ch;
        sent      = 0;
        need_long = allow_long;
        while (sent < n_items) begin
            ch  = $urandom_range(0, 1) ? TAG_ONE : TAG_ZERO;
            lvl = (ch == TAG_ONE) ? int'(lvl_one) : int'(lvl_zero);
            if (lvl >= SAMPLE_MAX) begin
                // No sample can exceed the level: send plain words
                push_sample($urandom_range(0, SAMPLE_MAX), ch);
                sent++;
            end else begin
                long_run  = need_long || (allow_long && $urandom_range(0, 99) < 2);
                need_long = 1'b0;
                len = long_run ? $urandom_range(72, 90) : $urandom_range(1, 8);
                lo  = (long_run && lvl < 900) ? 900 : lvl + 1;
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 12) begin
                        push_sample($urandom_range(0, SAMPLE_MAX), CHAN_W'($urandom_range(0, 3)));
                        sent++;
                    end
                    push_sample($urandom_range(lo, SAMPLE_MAX), ch);
                    sent++;
                end
                push_sample($urandom_range(0, lvl), ch);
                sent++;
            end
        end
        drop_sender();
    endtask

    // Channel-one pulses crossing the edge level and the level, no channel-zero
    // rise in between, so the shared counter runs past 255 and wraps
    task automatic run_crossing_wrap(input int pairs);
        int hi_from;
        int lo_to;
        hi_from = ((lvl_one > edge_lvl) ? int'(lvl_one) : int'(edge_lvl)) + 1;
        lo_to   = ((lvl_one < edge_lvl) ? int'(lvl_one) : int'(edge_lvl)) - 1;
        for (int i = 0; i < pairs; i++) begin
            push_sample($urandom_range(hi_from, SAMPLE_MAX), TAG_ONE);
            if ($urandom_range(0, 99) < 8)
                push_sample($urandom_range(0, SAMPLE_MAX), CHAN_W'($urandom_range(2, 3)));
            if ($urandom_range(0, 99) < 5)
                push_sample($urandom_range(0, edge_lvl), TAG_ZERO);
            push_sample($urandom_range(0, lo_to), TAG_ONE);
        end
        drop_sender();
    endtask

    // Output side: random stall per cycle, changed at the falling edge
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each output word with the oldest pending report
    always @(posedge i_clk) begin : check_reports
        burst_report_t got;
        burst_report_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser[0], m_axis_tdata[VAL_W-1:0], m_axis_tuser[1],
                    m_axis_tdata[2*VAL_W-1:VAL_W],
                    m_axis_tdata[2*VAL_W+COUNT_W-1:2*VAL_W]};
            if (pending_reports.size() == 0) begin
                failures++;
                if (failures <= SHOWN_LIMIT)
                    $display("%0t: word with none pending: %0d/%0d/%0d/%0d/%0d",
                             $realtime, got.burst_done, got.burst_value, got.mean_done,
                             got.mean_value, got.edge_count);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= SHOWN_LIMIT)
                        $display("%0t: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 $realtime, want.burst_done, want.burst_value, want.mean_done,
                                 want.mean_value, want.edge_count, got.burst_done,
                                 got.burst_value, got.mean_done, got.mean_value,
                                 got.edge_count);
                end
            end
        end
    end

    // Stop a hung run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        burst_report_t model_rpt;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;

        // Predictor starts from the reset state
        lvl_one   = LEVEL_ONE_RST;
        lvl_zero  = LEVEL_ZERO_RST;
        edge_lvl  = EDGE_LEVEL_RST;
        crossings = '0;
        for (int c = 0; c < 2; c++) begin
            burst_on[c]      = 1'b0;
            above_edge[c]    = 1'b0;
            burst_sums[c]    = '0;
            ring_pos[c]      = 0;
            channel_means[c] = '0;
            for (int i = 0; i < RING_DEPTH; i++) ring_vals[c][i] = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: typed expectation where given, predictor otherwise
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_word(directed_rows[i].sample, directed_rows[i].chan);
            model_rpt = compute_burst_report(directed_rows[i].sample, directed_rows[i].chan);
            pending_reports.push_back(directed_rows[i].typed ? directed_rows[i].want
                                                             : model_rpt);
        end
        drop_sender();

        // Lowest thresholds, sender idling
        send_gap_pct   = 65;
        recv_stall_pct = 0;
        load_thresholds(0, 0, 0);
        run_bursts(150, 1'b0);

        // Highest thresholds: nothing can start a burst or cross
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        load_thresholds(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        run_bursts(40, 1'b0);

        // Mid-range random thresholds, receiver stalling
        send_gap_pct   = 0;
        recv_stall_pct = 65;
        load_thresholds($urandom_range(0, 600), $urandom_range(0, 600),
                        $urandom_range(0, SAMPLE_MAX));
        run_bursts(300, 1'b1);

        // Counter wrap, both sides idling
        send_gap_pct   = 23;
        recv_stall_pct = 23;
        load_thresholds(300, 500, 200);
        run_crossing_wrap(270);

        // Random thresholds again, no idling
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        load_thresholds($urandom_range(0, 600), $urandom_range(0, 600),
                        $urandom_range(0, SAMPLE_MAX));
        run_bursts(300, 1'b1);

        // Drain, then allow a stray late word to show up
        wait_drained();
        repeat (48) @(posedge i_clk);
        if (pending_reports.size() != 0) failures += pending_reports.size();

        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
